[src/frame_bitmap_allocator_macros.svh]
// Assertion macros used by the frame bitmap allocator port checker.
`ifndef FRAME_BITMAP_ALLOCATOR_MACROS_SVH
`define FRAME_BITMAP_ALLOCATOR_MACROS_SVH

// Property sampled on the rising clock edge, muted while reset is held.
`define FBA_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Signal holds its value in the cycle after the condition.
`define FBA_ASSERT_HOLD(name, clk, rstn, cond, sig, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

[src/fba_pkg.sv]
// Shared types and constants of the frame bitmap allocator.
package fba_pkg;

    localparam int FRAME_W  = 12;
    localparam int REQ_W    = 3;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 8;
    localparam int ADDR_W   = 3;
    localparam int TDATA_W  = 16;

    localparam logic [CFG_W-1:0] WORDS_IN_USE_RESET = 8'd128;

    // register index taken from paddr[2]
    localparam logic REG_WORDS_IN_USE = 1'b0;

    localparam logic [REQ_W-1:0] REQ_MARK  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_TEST  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FIND  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_ALLOC = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_EXAM,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic accept;
        logic clear_wr;
        logic rd;
        logic exam;
        logic flag_range;
        logic flag_none;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic frame_op;
        logic find_op;
        logic in_range;
        logic word_full;
        logic out_free;
    } dp_stat_t;

endpackage

[src/fba_ctrl.sv]
// Sequencing state machine of the frame bitmap allocator.
module fba_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  fba_pkg::dp_stat_t   stat,
    output fba_pkg::ctrl_cmd_t  cmd
);

    fba_pkg::state_t state_reg;
    fba_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fba_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fba_pkg::ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = fba_pkg::ST_IDLE;
                end
            end
            fba_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = fba_pkg::ST_LOOK;
                end
            end
            fba_pkg::ST_LOOK:
            begin
                if ((stat.frame_op || stat.find_op) && stat.in_range)
                begin
                    state_next = fba_pkg::ST_EXAM;
                end
                else
                begin
                    state_next = fba_pkg::ST_DONE;
                end
            end
            fba_pkg::ST_EXAM:
            begin
                // full word during a search: move on to the next one
                if (stat.find_op && stat.word_full)
                begin
                    state_next = fba_pkg::ST_LOOK;
                end
                else
                begin
                    state_next = fba_pkg::ST_DONE;
                end
            end
            fba_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = fba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fba_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            fba_pkg::ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            fba_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.accept   = in_valid;
            end
            fba_pkg::ST_LOOK:
            begin
                cmd.rd         = (stat.frame_op || stat.find_op) && stat.in_range;
                cmd.flag_range = stat.frame_op && !stat.in_range;
                cmd.flag_none  = stat.find_op && !stat.in_range;
            end
            fba_pkg::ST_EXAM:
            begin
                cmd.exam = 1'b1;
            end
            fba_pkg::ST_DONE:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[src/fba_datapath.sv]
// Bitmap store, search hint, scan pointer and result registers.
module fba_datapath
#(
    parameter int WORD_BITS = 32,
    parameter int MAP_WORDS = 128
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  fba_pkg::ctrl_cmd_t                  cmd,
    input  logic [fba_pkg::CFG_W-1:0]           words_in_use,
    input  logic [fba_pkg::TDATA_W-1:0]         in_data,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [fba_pkg::TDATA_W-1:0]         out_data,
    output fba_pkg::dp_stat_t                   stat
);

    localparam int IDX_W  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CNT_W  = $clog2(MAP_WORDS + 1);
    localparam int LW     = (CNT_W > fba_pkg::CFG_W) ? CNT_W : fba_pkg::CFG_W;
    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int FW_W   = fba_pkg::FRAME_W - BIT_W;
    localparam int XW     = (LW > FW_W) ? LW : FW_W;
    localparam int FULL_W = IDX_W + BIT_W;

    logic [WORD_BITS-1:0]              mem [MAP_WORDS];
    logic [WORD_BITS-1:0]              rd_data_reg;

    logic [IDX_W-1:0]                  clr_ptr_reg;
    logic [IDX_W-1:0]                  hint_reg;
    logic [LW-1:0]                     scan_reg;
    logic [fba_pkg::REQ_W-1:0]         req_reg;
    logic [fba_pkg::FRAME_W-1:0]       frame_reg;
    logic [fba_pkg::STATUS_W-1:0]      status_reg;
    logic [fba_pkg::FRAME_W-1:0]       found_reg;
    logic                              used_reg;
    logic                              out_valid_reg;
    logic [fba_pkg::TDATA_W-1:0]       out_data_reg;

    logic [LW-1:0]                     live;
    logic [FW_W-1:0]                   fword;
    logic [BIT_W-1:0]                  fbit;
    logic                              frame_in_range;
    logic                              scan_in_range;
    logic                              frame_op;
    logic                              find_op;
    logic [IDX_W-1:0]                  rd_addr;
    logic [IDX_W-1:0]                  scan_idx;
    logic                              word_full;
    logic [BIT_W-1:0]                  first_zero;
    logic [WORD_BITS-1:0]              frame_mask;
    logic [WORD_BITS-1:0]              zero_mask;
    logic [FULL_W-1:0]                 found_full;
    logic                              wr_en;
    logic [IDX_W-1:0]                  wr_addr;
    logic [WORD_BITS-1:0]              wr_data;

    // words beyond the store act as the store size
    always_comb
    begin
        if (LW'(words_in_use) > LW'(MAP_WORDS))
        begin
            live = LW'(MAP_WORDS);
        end
        else
        begin
            live = LW'(words_in_use);
        end
    end

    assign fword          = frame_reg[fba_pkg::FRAME_W-1:BIT_W];
    assign fbit           = frame_reg[BIT_W-1:0];
    assign frame_in_range = XW'(fword) < XW'(live);
    assign scan_in_range  = scan_reg < live;
    assign frame_op       = (req_reg == fba_pkg::REQ_MARK) || (req_reg == fba_pkg::REQ_FREE)
                            || (req_reg == fba_pkg::REQ_TEST);
    assign find_op        = (req_reg == fba_pkg::REQ_FIND) || (req_reg == fba_pkg::REQ_ALLOC);
    assign scan_idx       = IDX_W'(scan_reg);
    assign rd_addr        = frame_op ? IDX_W'(fword) : scan_idx;

    assign word_full  = (rd_data_reg == '1);
    assign frame_mask = WORD_BITS'(1) << fbit;

    // lowest clear bit of the fetched word
    always_comb
    begin
        first_zero = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!rd_data_reg[i])
            begin
                first_zero = BIT_W'(i);
            end
        end
    end

    assign zero_mask  = WORD_BITS'(1) << first_zero;
    assign found_full = {scan_idx, first_zero};

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = rd_addr;
        wr_data = rd_data_reg;
        if (cmd.clear_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_ptr_reg;
            wr_data = '0;
        end
        else if (cmd.exam)
        begin
            case (req_reg)
                fba_pkg::REQ_MARK:
                begin
                    wr_en   = 1'b1;
                    wr_data = rd_data_reg | frame_mask;
                end
                fba_pkg::REQ_FREE:
                begin
                    wr_en   = 1'b1;
                    wr_data = rd_data_reg & ~frame_mask;
                end
                fba_pkg::REQ_ALLOC:
                begin
                    wr_en   = !word_full;
                    wr_data = rd_data_reg | zero_mask;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_ptr_reg   <= '0;
            hint_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_ptr_reg <= clr_ptr_reg + 1'b1;
            end
            if (cmd.exam)
            begin
                if ((req_reg == fba_pkg::REQ_FREE) && (XW'(fword) < XW'(hint_reg)))
                begin
                    hint_reg <= IDX_W'(fword);
                end
                else if (find_op && !word_full)
                begin
                    hint_reg <= scan_idx;
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg    <= in_data[fba_pkg::REQ_W-1:0];
            frame_reg  <= in_data[fba_pkg::REQ_W +: fba_pkg::FRAME_W];
            scan_reg   <= LW'(hint_reg);
            status_reg <= fba_pkg::STATUS_OK;
            found_reg  <= '0;
            used_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.flag_range)
            begin
                status_reg <= fba_pkg::STATUS_RANGE;
            end
            if (cmd.flag_none)
            begin
                status_reg <= fba_pkg::STATUS_NO_FREE;
            end
            if (cmd.exam)
            begin
                if (req_reg == fba_pkg::REQ_TEST)
                begin
                    used_reg <= |(rd_data_reg & frame_mask);
                end
                if (find_op)
                begin
                    if (word_full)
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                    else
                    begin
                        found_reg <= fba_pkg::FRAME_W'(found_full);
                    end
                end
            end
        end
        if (cmd.load_out)
        begin
            out_data_reg <= {1'b0, used_reg, found_reg, status_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign stat.clear_last = (clr_ptr_reg == IDX_W'(MAP_WORDS - 1));
    assign stat.frame_op   = frame_op;
    assign stat.find_op    = find_op;
    assign stat.in_range   = frame_op ? frame_in_range : scan_in_range;
    assign stat.word_full  = word_full;
    assign stat.out_free   = !out_valid_reg || out_ready;

endmodule

[src/frame_bitmap_allocator.sv]
// Top level of the first-fit page frame bitmap allocator.
//
//  Channel   Dir  Handshake                 Carries
//  s_axis    in   tvalid/tready             request: req_type, frame_number
//  m_axis    out  tvalid/tready             result: status, found_frame, frame_used
//  apb       in   psel/penable/pwrite/pready words_in_use register at byte 0
//
//  After reset the controller sweeps the bitmap store clearing one word per
//  cycle; no request is taken during the sweep.
//  Mark, free and test: fetch, update, load result; out-of-range and unknown
//  requests skip fetch and update. A request is taken only after the last one is loaded.
//  Find and allocate: each word scanned from the hint is addressed, then examined,
//  until a word with a clear bit is found or the scan runs off the live words. A waiting result
//  does not block the next request; a stalled m_axis holds the block only at a second result.
module frame_bitmap_allocator
#(
    parameter int WORD_BITS = 32,
    parameter int MAP_WORDS = 128
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [2:0] req_type, [14:3] frame_number, [15] zero
    input  logic [fba_pkg::TDATA_W-1:0]        s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [1:0] status, [13:2] found_frame, [14] frame_used, [15] zero
    output logic [fba_pkg::TDATA_W-1:0]        m_axis_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fba_pkg::ADDR_W-1:0]         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    fba_pkg::ctrl_cmd_t           cmd;
    fba_pkg::dp_stat_t            stat;
    logic [fba_pkg::CFG_W-1:0]    words_in_use_reg;
    logic                         cfg_wr;
    logic                         reg_sel;

    // Register file: one register, index from bit 2 of the byte address.
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == fba_pkg::REG_WORDS_IN_USE);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_in_use_reg <= fba_pkg::WORDS_IN_USE_RESET;
        end
        else if (cfg_wr)
        begin
            words_in_use_reg <= pwdata[fba_pkg::CFG_W-1:0];
        end
    end

    // Return the register on its own address, zero elsewhere.
    assign prdata = reg_sel ? 32'(words_in_use_reg) : 32'd0;

    // Sequence the request: clear sweep, fetch, examine, load result.
    fba_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the bitmap, hint, scan pointer and result register.
    fba_datapath
    #(
        .WORD_BITS (WORD_BITS),
        .MAP_WORDS (MAP_WORDS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .words_in_use (words_in_use_reg),
        .in_data      (s_axis_tdata),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_data     (m_axis_tdata),
        .stat         (stat)
    );

    assign s_axis_tready = cmd.in_ready;

endmodule

[src/fba_port_checker.sv]
// Port-level checks of the frame bitmap allocator and their binding.
`include "frame_bitmap_allocator_macros.svh"

module fba_port_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [fba_pkg::TDATA_W-1:0] m_axis_tdata
);

    `FBA_ASSERT_HOLD(a_out_valid_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
    `FBA_ASSERT_HOLD(a_out_data_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tdata, "result changed while stalled")
    `FBA_ASSERT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request taken while busy")
    `FBA_ASSERT(a_error_fields_zero, clk, rst_n, m_axis_tvalid && (m_axis_tdata[1:0] != fba_pkg::STATUS_OK) |-> (m_axis_tdata[15:2] == 14'd0), "error result carries data")
    `FBA_ASSERT(a_used_only_test, clk, rst_n, m_axis_tvalid && m_axis_tdata[14] |-> (m_axis_tdata[13:0] == 14'd0), "used flag with other fields set")

endmodule

bind frame_bitmap_allocator fba_port_checker u_port_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
